// ===== rtl/islt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// islt_pkg
// Beat types, phase codes and step constants shared by the inverted slide
// LED transition block.
// ----------------------------------------------------------------------------
package islt_pkg;

    localparam int unsigned COL_W   = 5;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned STEP_W  = 5;
    localparam int unsigned HOLD_W  = 16;

    // phase codes
    localparam logic [PHASE_W-1:0] PH_BEGIN = 3'd0;
    localparam logic [PHASE_W-1:0] PH_IN    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_HOLD  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_OUT   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_END   = 3'd4;

    // step boundaries
    localparam logic [STEP_W-1:0] STEP_SLIDE_END = 5'd8;
    localparam logic [STEP_W-1:0] STEP_FILL_END  = 5'd16;
    localparam logic [STEP_W-1:0] STEP_OUT_BASE  = 5'd10;
    localparam logic [STEP_W-1:0] STEP_BLANK_TOP = 5'd9;
    localparam logic [STEP_W-1:0] SHIFT_MAX      = 5'd7;
    localparam logic [STEP_W-1:0] STEP_ZERO      = 5'd0;
    localparam logic [STEP_W-1:0] STEP_ONE       = 5'd1;

    localparam logic [HOLD_W-1:0] HOLD_MAX = 16'hFFFF;
    localparam logic [HOLD_W-1:0] HOLD_ONE = 16'd1;

    typedef struct packed {
        logic [BYTE_W-1:0] target_byte;
        logic [COL_W-1:0]  column_index;
        logic              tick_last;
    } t_in_beat;

    typedef struct packed {
        logic [BYTE_W-1:0]  shown_byte;
        logic [COL_W-1:0]   shown_index;
        logic [PHASE_W-1:0] phase_now;
        logic               finished;
    } t_out_beat;

    // update decided for one beat
    typedef struct packed {
        logic               wr_en;
        logic [BYTE_W-1:0]  wr_data;
        logic [PHASE_W-1:0] n_phase;
        logic [STEP_W-1:0]  n_step;
        logic [HOLD_W-1:0]  n_hold;
    } t_step_ctl;

endpackage

// ===== rtl/islt_frame.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// islt_frame
// Shown frame store: one byte per column, cleared at reset, read and
// written at the column of the beat in flight.
// ----------------------------------------------------------------------------
module islt_frame #(
    parameter int unsigned COLUMNS = 32,
    parameter int unsigned DEPTH   = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [islt_pkg::COL_W-1:0]  i_col,
    input  logic                        i_wr_en,
    input  logic [islt_pkg::BYTE_W-1:0] i_wr_data,
    output logic                        o_col_ok,
    output logic [islt_pkg::BYTE_W-1:0] o_rd_data
);
    import islt_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]     addr;

    assign addr      = i_col[AW-1:0];
    assign o_col_ok  = (int'(i_col) < COLUMNS);
    assign o_rd_data = o_col_ok ? r_mem[addr] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < int'(DEPTH); i++) begin
                r_mem[i] <= '0;
            end
        end else if (i_wr_en) begin
            r_mem[addr] <= i_wr_data;
        end
    end

endmodule

// ===== rtl/islt_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// islt_step
// Per-beat transition logic: next phase, step and hold count, the new
// column value and the result beat.
// ----------------------------------------------------------------------------
module islt_step (
    input  islt_pkg::t_in_beat           i_beat,
    input  logic                         i_col_ok,
    input  logic [islt_pkg::BYTE_W-1:0]  i_cur,
    input  logic [islt_pkg::PHASE_W-1:0] i_phase,
    input  logic [islt_pkg::STEP_W-1:0]  i_step,
    input  logic [islt_pkg::HOLD_W-1:0]  i_hold,
    input  logic [islt_pkg::HOLD_W-1:0]  i_hold_duration,
    output islt_pkg::t_step_ctl          o_ctl,
    output islt_pkg::t_out_beat          o_beat
);
    import islt_pkg::*;

    logic [BYTE_W-1:0]  inv;
    logic [BYTE_W-1:0]  val;
    logic [BYTE_W-1:0]  cur_shl;
    logic [STEP_W-1:0]  out_sub;
    logic [PHASE_W-1:0] n_phase;
    logic [STEP_W-1:0]  n_step;
    logic [HOLD_W-1:0]  n_hold;
    logic               wr;
    logic               go_out;

    always_comb begin
        inv     = ~i_beat.target_byte;
        cur_shl = {i_cur[BYTE_W-2:0], 1'b0};
        out_sub = i_step - STEP_OUT_BASE;
        go_out  = 1'b0;
        n_phase = i_phase;
        n_step  = i_step;
        n_hold  = i_hold;
        wr      = 1'b0;
        val     = i_cur;

        if (i_phase == PH_HOLD) begin
            if (i_hold >= i_hold_duration) begin
                go_out = 1'b1;
            end else if (i_hold != HOLD_MAX) begin
                n_hold = i_hold + HOLD_ONE;
            end
        end

        if (i_phase == PH_BEGIN || i_phase == PH_IN) begin
            n_phase = PH_IN;
            // low step bits inverted give 7 - step and 15 - step
            if (i_step < STEP_SLIDE_END) begin
                val = inv >> (~i_step[2:0]);
                wr  = 1'b1;
            end else if (i_step < STEP_FILL_END) begin
                val = cur_shl | (i_beat.target_byte >> (~i_step[2:0]));
                wr  = 1'b1;
            end else begin
                n_phase = PH_HOLD;
            end
            n_step = i_step + STEP_ONE;
        end else if (i_phase == PH_OUT || go_out) begin
            n_phase = PH_OUT;
            if (i_step > STEP_BLANK_TOP) begin
                val = cur_shl | ((out_sub > SHIFT_MAX) ? '0 : (inv >> out_sub[2:0]));
                wr  = 1'b1;
            end else if (i_step != STEP_ZERO) begin
                val = cur_shl;
                wr  = 1'b1;
            end else begin
                n_phase = PH_END;
            end
            n_step = i_step - STEP_ONE;
        end
    end

    assign o_ctl.wr_en   = wr & i_col_ok;
    assign o_ctl.wr_data = val;
    assign o_ctl.n_phase = n_phase;
    assign o_ctl.n_step  = n_step;
    assign o_ctl.n_hold  = n_hold;

    assign o_beat.shown_byte  = (wr && i_col_ok) ? val : i_cur;
    assign o_beat.shown_index = i_beat.column_index;
    assign o_beat.phase_now   = n_phase;
    assign o_beat.finished    = (n_phase >= PH_END);

endmodule

// ===== rtl/inverted_slide_led_transition_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverted_slide_led_transition_core
// Inverted slide in / hold / slide out animation of an LED column frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_beat) carries one target
//   column per beat; tick_last marks the final column of a display tick and
//   commits the step index, phase and hold count.
//   Output channel (o_out_valid / i_out_stall / o_out_beat) returns one beat
//   per input beat, in order: the updated column, its index, the phase and
//   the finished flag.
//   i_cfg_wr_en / i_cfg_wr_data load the hold duration in ticks; write it
//   only while no beat is in flight.
//   An accepted beat passes the input register, then one pass of update
//   logic into the output register; the frame store is read and written
//   in that same pass. One beat is accepted every cycle while o_in_stall
//   is low.
//   Reset clears the frame to blank, phase to begin, step and hold count to
//   zero, the hold duration to zero, and empties both pipeline registers.
//   While the receiver stalls, the output beat holds; the input register
//   keeps one more beat, then o_in_stall rises.
// ----------------------------------------------------------------------------
module inverted_slide_led_transition_core #(
    parameter int unsigned COLUMNS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [islt_pkg::HOLD_W-1:0] i_cfg_wr_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  islt_pkg::t_in_beat          i_in_beat,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output islt_pkg::t_out_beat         o_out_beat
);
    import islt_pkg::*;

    localparam int unsigned MAX_COLS    = 1 << COL_W;
    localparam int unsigned FRAME_DEPTH = (COLUMNS < MAX_COLS) ? COLUMNS : MAX_COLS;

    logic               r_in_valid;
    t_in_beat           r_in_beat;
    logic               r_out_valid;
    t_out_beat          r_out_beat;
    logic [PHASE_W-1:0] r_phase;
    logic [STEP_W-1:0]  r_step;
    logic [HOLD_W-1:0]  r_hold;
    logic [HOLD_W-1:0]  r_hold_duration;

    logic               out_free;
    logic               fire;
    logic               col_ok;
    logic [BYTE_W-1:0]  cur;
    t_step_ctl          ctl;
    t_out_beat          n_out_beat;

    assign out_free    = ~r_out_valid | ~i_out_stall;
    assign fire        = r_in_valid & out_free;
    assign o_in_stall  = r_in_valid & ~out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    islt_frame #(
        .COLUMNS (COLUMNS),
        .DEPTH   (FRAME_DEPTH)
    ) u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_col     (r_in_beat.column_index),
        .i_wr_en   (fire & ctl.wr_en),
        .i_wr_data (ctl.wr_data),
        .o_col_ok  (col_ok),
        .o_rd_data (cur)
    );

    islt_step u_step (
        .i_beat          (r_in_beat),
        .i_col_ok        (col_ok),
        .i_cur           (cur),
        .i_phase         (r_phase),
        .i_step          (r_step),
        .i_hold          (r_hold),
        .i_hold_duration (r_hold_duration),
        .o_ctl           (ctl),
        .o_beat          (n_out_beat)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_beat <= i_in_beat;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_beat <= n_out_beat;
        end
    end

    // sequence state commits on the last column of a tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_BEGIN;
            r_step  <= '0;
            r_hold  <= '0;
        end else if (fire && r_in_beat.tick_last) begin
            r_phase <= ctl.n_phase;
            r_step  <= ctl.n_step;
            r_hold  <= ctl.n_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_duration <= '0;
        end else if (i_cfg_wr_en) begin
            r_hold_duration <= i_cfg_wr_data;
        end
    end

    a_phase_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fire && r_in_beat.tick_last) |=> $stable(r_phase))
        else $error("phase changed without a committed last beat");

    a_end_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_END) |=> (r_phase == PH_END))
        else $error("left the ended phase");

    a_hold_only_holding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_HOLD) |=> $stable(r_hold))
        else $error("hold count moved outside holding");

    a_finished_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_beat.finished == (r_out_beat.phase_now >= PH_END)))
        else $error("finished flag disagrees with phase");

endmodule

// ===== verif/islt_column_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// islt_column_checker
// Watches both beat channels of the inverted slide LED transition core. It
// keeps its own frame, phase, step and hold state, predicts the result of
// every accepted input beat and compares each output beat with the oldest
// prediction.
// ----------------------------------------------------------------------------
module islt_column_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [islt_pkg::HOLD_W-1:0]   i_cfg_wr_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  islt_pkg::t_in_beat            i_in_beat,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  islt_pkg::t_out_beat           i_out_beat,
    output int                            o_mismatches,
    output int                            o_columns_owed,
    output logic [islt_pkg::PHASE_W-1:0]  o_anim_phase
);
    import islt_pkg::*;

    localparam int unsigned FRAME_COLS = 32;

    logic [BYTE_W-1:0]  frame_cols [FRAME_COLS];
    logic [PHASE_W-1:0] anim_phase;
    logic [STEP_W-1:0]  step_idx;
    logic [HOLD_W-1:0]  hold_ticks;
    logic [HOLD_W-1:0]  hold_len;
    t_out_beat          expected_columns [$];
    int                 fail_total;

    // applies one column beat to the frame and returns the column it shows
    function automatic t_out_beat advance_frame(input t_in_beat b);
        logic [BYTE_W-1:0]  cur;
        logic [BYTE_W-1:0]  inv;
        logic [BYTE_W-1:0]  val;
        logic [STEP_W-1:0]  nstep;
        logic [PHASE_W-1:0] nphase;
        logic [HOLD_W-1:0]  nhold;
        logic               wr;
        logic               go_out;
        t_out_beat          r;
        cur    = frame_cols[b.column_index];
        inv    = ~b.target_byte;
        val    = cur;
        nstep  = step_idx;
        nphase = anim_phase;
        nhold  = hold_ticks;
        wr     = 1'b0;
        go_out = 1'b0;
        if (anim_phase == PH_HOLD) begin
            if (hold_ticks >= hold_len) begin
                go_out = 1'b1;
            end else if (hold_ticks < HOLD_MAX) begin
                nhold = hold_ticks + HOLD_ONE;
            end
        end
        if (anim_phase == PH_BEGIN || anim_phase == PH_IN) begin
            nphase = PH_IN;
            if (step_idx < STEP_SLIDE_END) begin
                val = inv >> (SHIFT_MAX - step_idx);
                wr  = 1'b1;
            end else if (step_idx < STEP_FILL_END) begin
                val = (cur << 1) | (b.target_byte >> (STEP_FILL_END - STEP_ONE - step_idx));
                wr  = 1'b1;
            end else begin
                nphase = PH_HOLD;
            end
            nstep = step_idx + STEP_ONE;
        end else if (anim_phase == PH_OUT || go_out) begin
            nphase = PH_OUT;
            if (step_idx > STEP_BLANK_TOP) begin
                // shift amounts past 7 come out as zero here
                val = (cur << 1) | (inv >> (step_idx - STEP_OUT_BASE));
                wr  = 1'b1;
            end else if (step_idx > STEP_ZERO) begin
                val = cur << 1;
                wr  = 1'b1;
            end else begin
                nphase = PH_END;
            end
            nstep = step_idx - STEP_ONE;
        end
        if (wr) begin
            frame_cols[b.column_index] = val;
            cur = val;
        end
        // only the last column of a tick commits the sequence state
        if (b.tick_last) begin
            anim_phase = nphase;
            step_idx   = nstep;
            hold_ticks = nhold;
        end
        r.shown_byte  = cur;
        r.shown_index = b.column_index;
        r.phase_now   = nphase;
        r.finished    = (nphase >= PH_END);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            for (int i = 0; i < FRAME_COLS; i++) begin
                frame_cols[i] = '0;
            end
            anim_phase = PH_BEGIN;
            step_idx   = STEP_ZERO;
            hold_ticks = '0;
            hold_len   = '0;
            fail_total = 0;
            expected_columns.delete();
        end else begin
            if (i_cfg_wr_en) begin
                hold_len = i_cfg_wr_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_columns.size() == 0) begin
                    $error("output beat with no column expected");
                    fail_total++;
                end else begin
                    want = expected_columns.pop_front();
                    if (i_out_beat.shown_byte !== want.shown_byte) begin
                        $error("shown_byte: expected %0h, got %0h",
                               want.shown_byte, i_out_beat.shown_byte);
                        fail_total++;
                    end
                    if (i_out_beat.shown_index !== want.shown_index) begin
                        $error("shown_index: expected %0d, got %0d",
                               want.shown_index, i_out_beat.shown_index);
                        fail_total++;
                    end
                    if (i_out_beat.phase_now !== want.phase_now) begin
                        $error("phase_now: expected %0d, got %0d",
                               want.phase_now, i_out_beat.phase_now);
                        fail_total++;
                    end
                    if (i_out_beat.finished !== want.finished) begin
                        $error("finished: expected %0b, got %0b",
                               want.finished, i_out_beat.finished);
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_columns.push_back(advance_frame(i_in_beat));
            end
        end
        o_mismatches   <= fail_total;
        o_columns_owed <= expected_columns.size();
        o_anim_phase   <= anim_phase;
    end

endmodule

// ===== verif/inverted_slide_led_transition_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverted_slide_led_transition_core_tb
// Drives frame ticks of target columns through one full slide in, hold and
// slide out sequence and on into the ended state, with random gaps on both
// channels and hold length changes between phases. A checker beside the
// core predicts every output beat.
// ----------------------------------------------------------------------------
module inverted_slide_led_transition_core_tb;
    import islt_pkg::*;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [HOLD_W-1:0]  cfg_wr_data = '0;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    t_in_beat           in_beat     = '0;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    t_out_beat          out_beat;

    int                 mismatches;
    int                 columns_owed;
    logic [PHASE_W-1:0] anim_phase;

    int sent_beats = 0;
    int ticks_sent = 0;
    int rx_beats   = 0;
    int ended_beats;
    int guard;

    logic [BYTE_W-1:0] edge_vals [8] = '{8'h00, 8'hFF, 8'h80, 8'h01,
                                         8'hAA, 8'h55, 8'h0F, 8'hF0};

    inverted_slide_led_transition_core #(
        .COLUMNS (32)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_beat     (in_beat),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_beat    (out_beat)
    );

    islt_column_checker chk (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_beat      (in_beat),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_beat     (out_beat),
        .o_mismatches   (mismatches),
        .o_columns_owed (columns_owed),
        .o_anim_phase   (anim_phase)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_column(input logic [BYTE_W-1:0] tgt, input logic [COL_W-1:0] col,
                               input logic last);
        int       gap;
        t_in_beat b;
        b.target_byte  = tgt;
        b.column_index = col;
        b.tick_last    = last;
        // every 160 beats a stretch of back-to-back beats
        gap = ((sent_beats % 160) < 40) ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (in_stall);
        sent_beats++;
        if (last) begin
            ticks_sent++;
        end
    endtask

    // mostly whole ticks of columns 0..n-1, sometimes stray columns
    task automatic send_frame_tick();
        int n;
        if ($urandom_range(0, 99) < 85) begin
            n = ($urandom_range(0, 9) == 0) ? 32 : $urandom_range(1, 24);
            for (int k = 0; k < n; k++) begin
                send_column(BYTE_W'($urandom), COL_W'(k), k == n - 1);
            end
        end else begin
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++) begin
                send_column(BYTE_W'($urandom), COL_W'($urandom), 1'($urandom));
            end
        end
    endtask

    // wait until every column sent has come back, then let the pipe settle
    task automatic drain_columns();
        in_valid <= 1'b0;
        @(posedge clk);
        while (columns_owed != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_hold(input logic [HOLD_W-1:0] len);
        drain_columns();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // receiver: random stall per beat, one long hold-off to fill the core
    initial begin
        int g;
        bit long_done;
        long_done = 1'b0;
        forever begin
            // long hold-off starts only while the sender is offering beats
            if (!long_done && rx_beats >= 250 && in_valid) begin
                g         = 150;
                long_done = 1'b1;
            end else begin
                g = ((rx_beats % 200) < 50) ? 0 : $urandom_range(0, 16);
            end
            if (g > 0) begin
                out_stall <= 1'b1;
                repeat (g) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
            rx_beats++;
        end
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d columns outstanding", columns_owed);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_hold('0);

        // edge columns and patterns through the early slide steps
        send_column(8'h00, 5'd0, 1'b0);
        send_column(8'hFF, 5'd31, 1'b0);
        send_column(8'hFF, 5'd0, 1'b1);
        for (int i = 0; i < 8; i++) begin
            send_column(edge_vals[i], 5'd0, 1'b0);
            send_column(~edge_vals[i], 5'd31, 1'b1);
        end

        // long hold so the hold phase cannot slip away before it is looked at
        write_hold(HOLD_MAX);
        while (anim_phase != PH_HOLD) send_frame_tick();
        repeat (10) send_frame_tick();

        // shorter hold, sometimes below the count already reached
        write_hold(($urandom_range(0, 3) == 0) ? HOLD_W'(0) : HOLD_W'($urandom_range(1, 25)));
        while (anim_phase != PH_OUT) send_frame_tick();
        while (anim_phase != PH_END) send_frame_tick();

        write_hold(HOLD_W'($urandom));
        ended_beats = sent_beats;
        while (sent_beats < 900 || sent_beats - ended_beats < 40) send_frame_tick();

        in_valid <= 1'b0;
        guard = 0;
        @(posedge clk);
        while (columns_owed != 0 && guard < 20000) begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        if (columns_owed != 0) begin
            $error("%0d expected columns never arrived", columns_owed);
        end

        $display("covered %0d column beats in %0d ticks, %0d results checked",
                 sent_beats, ticks_sent, rx_beats);
        $display("slide in, hold at several lengths, slide out and the ended frame");
        if (mismatches == 0 && columns_owed == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
